// File: hw/rtl/cube_map_face_select_unit_defines.svh
// ----------------------------------------------------------------------------
// Cube map face select assertion macros
// Shared concurrent assertion forms for the face select checker.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH
`define CUBE_MAP_FACE_SELECT_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define CMFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cmfs same-cycle check failed");

// next-cycle implication, off during reset
`define CMFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cmfs next-cycle check failed");

// next-cycle implication, also checked across reset
`define CMFS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("cmfs reset check failed");

`endif

// File: hw/rtl/cmfs_pkg.sv
// ----------------------------------------------------------------------------
// Cube map face select package
// Field widths, face codes and the tag that rides along the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmfs_pkg;

   localparam int DIR_W      = 16;   // input component width, Q1.15
   localparam int MAG_W      = 17;   // magnitude / face-local coordinate width
   localparam int DIV_W      = 17;   // divisor (2 * ma) and remainder width
   localparam int CSR_W      = 13;   // face_size register width
   localparam int TEXEL_W    = 12;   // texel coordinate width
   localparam int FACE_SIZE_RESET = 256;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } cmfs_face_type;

   typedef struct packed {
      cmfs_face_type face;
      logic          nz;     // direction is not the zero vector
   } cmfs_tag_type;

endpackage

// File: hw/rtl/cube_map_face_select_unit.sv
// Request path: major axis stage, offset stage, scale stage, divider stages, output stage.
// Throughput: one request per cycle; one quotient bit per divider stage sets the depth.
// Stalls ripple back stage by stage; empty stages keep filling while the output waits.
// Reset: synchronous, active high; empties every stage and loads face_size = 256
// (capped at MAX_FACE_SIZE).
// ----------------------------------------------------------------------------
// Cube map face select unit
// Picks the cube face of a Q1.15 direction and forms clamped texel coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cube_map_face_select_unit #(
   parameter int MAX_FACE_SIZE = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmfs_pkg::CSR_W-1:0]       csr_face_size,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [cmfs_pkg::DIR_W-1:0] req_dir_x,
   input  logic signed [cmfs_pkg::DIR_W-1:0] req_dir_y,
   input  logic signed [cmfs_pkg::DIR_W-1:0] req_dir_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_face,
   output logic [cmfs_pkg::TEXEL_W-1:0]     rsp_texel_x,
   output logic [cmfs_pkg::TEXEL_W-1:0]     rsp_texel_y,
   output logic                             rsp_valid_res
);
   import cmfs_pkg::*;

   localparam int SIZE_W = $clog2(MAX_FACE_SIZE + 1);
   localparam int NUM_W  = DIV_W + SIZE_W;
   localparam int CMP_W  = (SIZE_W > CSR_W) ? SIZE_W : CSR_W;
   localparam int RESET_SIZE = (MAX_FACE_SIZE < FACE_SIZE_RESET) ? MAX_FACE_SIZE
                                                                 : FACE_SIZE_RESET;

   // ---------------- face size register (stored already clamped) ----------
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic [CMP_W-1:0]  csr_wide;

   assign csr_ready = 1'b1;
   assign csr_wide  = CMP_W'(csr_face_size);

   always_comb begin
      priority if (csr_wide == '0) begin
         size_in = SIZE_W'(1);
      end else if (csr_wide > CMP_W'(MAX_FACE_SIZE)) begin
         size_in = SIZE_W'(MAX_FACE_SIZE);
      end else begin
         size_in = SIZE_W'(csr_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(RESET_SIZE);
      end else if (csr_valid && csr_ready) begin
         size_ff <= size_in;
      end
   end

   // ---------------- handshake chain ----------------
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic rdy1, rdy2, rdy3, rdyo;
   logic div_in_ready;
   logic div_out_valid;

   assign rdyo      = !vo_ff || rsp_ready;
   assign rdy3      = !v3_ff || div_in_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   // ---------------- stage 1: major axis and face ----------------
   logic signed [MAG_W-1:0] xs, ys, zs;
   logic [MAG_W-1:0]        ax, ay, az;
   logic [MAG_W-1:0]        ma_in;
   logic signed [MAG_W-1:0] sc_in, tc_in;
   cmfs_face_type           face_in;
   logic                    nz_in;

   logic [MAG_W-1:0]        ma_ff;
   logic signed [MAG_W-1:0] sc_ff, tc_ff;
   cmfs_tag_type            tag1_ff;

   always_comb begin
      xs = {req_dir_x[DIR_W-1], req_dir_x};
      ys = {req_dir_y[DIR_W-1], req_dir_y};
      zs = {req_dir_z[DIR_W-1], req_dir_z};
      ax = xs[MAG_W-1] ? unsigned'(-xs) : unsigned'(xs);
      ay = ys[MAG_W-1] ? unsigned'(-ys) : unsigned'(ys);
      az = zs[MAG_W-1] ? unsigned'(-zs) : unsigned'(zs);
      nz_in = (req_dir_x != '0) || (req_dir_y != '0) || (req_dir_z != '0);
      // ties favor X, then Y
      priority if (ax >= ay && ax >= az) begin
         ma_in = ax;
         tc_in = -ys;
         if (!xs[MAG_W-1] && nz_in && (xs != '0)) begin
            face_in = FACE_POS_X;
            sc_in   = -zs;
         end else begin
            face_in = nz_in ? FACE_NEG_X : FACE_POS_X;
            sc_in   = zs;
         end
      end else if (ay >= az) begin
         ma_in = ay;
         sc_in = xs;
         if (!ys[MAG_W-1]) begin
            face_in = FACE_POS_Y;
            tc_in   = zs;
         end else begin
            face_in = FACE_NEG_Y;
            tc_in   = -zs;
         end
      end else begin
         ma_in = az;
         tc_in = -ys;
         if (!zs[MAG_W-1]) begin
            face_in = FACE_POS_Z;
            sc_in   = xs;
         end else begin
            face_in = FACE_NEG_Z;
            sc_in   = -xs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         ma_ff        <= ma_in;
         sc_ff        <= sc_in;
         tc_ff        <= tc_in;
         tag1_ff.face <= face_in;
         tag1_ff.nz   <= nz_in;
      end
   end

   // ---------------- stage 2: offset by ma, form 2*ma ----------------
   logic [MAG_W:0]   sn_full, tn_full;
   logic [MAG_W-1:0] sn_ff, tn_ff;
   logic [DIV_W-1:0] den2_ff;
   cmfs_tag_type     tag2_ff;

   // c + ma lies in [0, 2*ma], so the low bits hold it exactly
   assign sn_full = {sc_ff[MAG_W-1], sc_ff} + {1'b0, ma_ff};
   assign tn_full = {tc_ff[MAG_W-1], tc_ff} + {1'b0, ma_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         sn_ff   <= sn_full[MAG_W-1:0];
         tn_ff   <= tn_full[MAG_W-1:0];
         den2_ff <= {ma_ff[MAG_W-2:0], 1'b0};
         tag2_ff <= tag1_ff;
      end
   end

   // ---------------- stage 3: scale by face size ----------------
   logic [NUM_W-1:0] num_s_ff, num_t_ff;
   logic [DIV_W-1:0] den3_ff;
   cmfs_tag_type     tag3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         num_s_ff <= NUM_W'(sn_ff) * NUM_W'(size_ff);
         num_t_ff <= NUM_W'(tn_ff) * NUM_W'(size_ff);
         den3_ff  <= den2_ff;
         tag3_ff  <= tag2_ff;
      end
   end

   // ---------------- divider ----------------
   logic [SIZE_W-1:0] quo_s, quo_t;
   cmfs_tag_type      tag_d;

   cmfs_div_pipe #(
      .QUO_W (SIZE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (div_in_ready),
      .in_num_s  (num_s_ff),
      .in_num_t  (num_t_ff),
      .in_den    (den3_ff),
      .in_tag    (tag3_ff),
      .out_valid (div_out_valid),
      .out_ready (rdyo),
      .out_quo_s (quo_s),
      .out_quo_t (quo_t),
      .out_tag   (tag_d)
   );

   // ---------------- output stage: clamp to size - 1 ----------------
   logic [SIZE_W-1:0] size_m1;
   logic [SIZE_W-1:0] cl_s, cl_t;
   logic [2:0]             face_ff;
   logic [TEXEL_W-1:0]     tx_ff, ty_ff;
   logic                   res_ff;

   assign size_m1 = size_ff - SIZE_W'(1);
   assign cl_s    = (quo_s > size_m1) ? size_m1 : quo_s;
   assign cl_t    = (quo_t > size_m1) ? size_m1 : quo_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (rdyo) begin
         vo_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdyo && div_out_valid) begin
         face_ff <= tag_d.nz ? tag_d.face : FACE_POS_X;
         tx_ff   <= tag_d.nz ? TEXEL_W'(cl_s) : '0;
         ty_ff   <= tag_d.nz ? TEXEL_W'(cl_t) : '0;
         res_ff  <= tag_d.nz;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_face      = face_ff;
   assign rsp_texel_x   = tx_ff;
   assign rsp_texel_y   = ty_ff;
   assign rsp_valid_res = res_ff;

endmodule

// File: hw/rtl/cmfs_div_pipe.sv
// ----------------------------------------------------------------------------
// Cube map face select divider pipeline
// Two-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmfs_div_pipe #(
   parameter int QUO_W = 13
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [cmfs_pkg::DIV_W+QUO_W-1:0]      in_num_s,
   input  logic [cmfs_pkg::DIV_W+QUO_W-1:0]      in_num_t,
   input  logic [cmfs_pkg::DIV_W-1:0]            in_den,
   input  cmfs_pkg::cmfs_tag_type                in_tag,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [QUO_W-1:0]                      out_quo_s,
   output logic [QUO_W-1:0]                      out_quo_t,
   output cmfs_pkg::cmfs_tag_type                out_tag
);
   import cmfs_pkg::*;

   // one restoring step: shift in the next numerator bit, compare, subtract
   function automatic logic [DIV_W+QUO_W-1:0] div_step(
      input logic [DIV_W-1:0] rem,
      input logic [QUO_W-1:0] sh,
      input logic [DIV_W-1:0] den
   );
      logic [DIV_W:0] r2;
      logic [DIV_W:0] diff;
      logic           ge;
      r2   = {rem, sh[QUO_W-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      return {(ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0]), ((sh << 1) | QUO_W'(ge))};
   endfunction

   logic                v_ff     [QUO_W];
   logic [DIV_W-1:0]    rem_s_ff [QUO_W];
   logic [DIV_W-1:0]    rem_t_ff [QUO_W];
   logic [QUO_W-1:0]    sh_s_ff  [QUO_W];
   logic [QUO_W-1:0]    sh_t_ff  [QUO_W];
   logic [DIV_W-1:0]    den_ff   [QUO_W];
   cmfs_tag_type        tag_ff   [QUO_W];
   logic                rdy      [QUO_W+1];

   assign rdy[QUO_W] = out_ready;

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic                   src_v;
         logic [DIV_W-1:0]       src_rem_s;
         logic [DIV_W-1:0]       src_rem_t;
         logic [QUO_W-1:0]       src_sh_s;
         logic [QUO_W-1:0]       src_sh_t;
         logic [DIV_W-1:0]       src_den;
         cmfs_tag_type           src_tag;
         logic [DIV_W+QUO_W-1:0] step_s_in;
         logic [DIV_W+QUO_W-1:0] step_t_in;

         if (k == 0) begin : g_head
            // numerator high part is below the divisor since quotient <= size
            always_comb begin
               src_v     = in_valid;
               src_rem_s = in_num_s[DIV_W+QUO_W-1:QUO_W];
               src_rem_t = in_num_t[DIV_W+QUO_W-1:QUO_W];
               src_sh_s  = in_num_s[QUO_W-1:0];
               src_sh_t  = in_num_t[QUO_W-1:0];
               src_den   = in_den;
               src_tag   = in_tag;
            end
         end else begin : g_body
            always_comb begin
               src_v     = v_ff[k-1];
               src_rem_s = rem_s_ff[k-1];
               src_rem_t = rem_t_ff[k-1];
               src_sh_s  = sh_s_ff[k-1];
               src_sh_t  = sh_t_ff[k-1];
               src_den   = den_ff[k-1];
               src_tag   = tag_ff[k-1];
            end
         end

         assign rdy[k]    = !v_ff[k] || rdy[k+1];
         assign step_s_in = div_step(src_rem_s, src_sh_s, src_den);
         assign step_t_in = div_step(src_rem_t, src_sh_t, src_den);

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (rdy[k]) begin
               v_ff[k] <= src_v;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[k] && src_v) begin
               rem_s_ff[k] <= step_s_in[DIV_W+QUO_W-1:QUO_W];
               sh_s_ff[k]  <= step_s_in[QUO_W-1:0];
               rem_t_ff[k] <= step_t_in[DIV_W+QUO_W-1:QUO_W];
               sh_t_ff[k]  <= step_t_in[QUO_W-1:0];
               den_ff[k]   <= src_den;
               tag_ff[k]   <= src_tag;
            end
         end
      end
   endgenerate

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QUO_W-1];
   assign out_quo_s = sh_s_ff[QUO_W-1];
   assign out_quo_t = sh_t_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

// File: hw/rtl/cmfs_checker.sv
// ----------------------------------------------------------------------------
// Cube map face select checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cube_map_face_select_unit_defines.svh"

module cmfs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_face,
   input logic [cmfs_pkg::TEXEL_W-1:0] rsp_texel_x,
   input logic [cmfs_pkg::TEXEL_W-1:0] rsp_texel_y,
   input logic                         rsp_valid_res
);
   import cmfs_pkg::*;

   logic                 zero_payload;
   logic [2*TEXEL_W+3:0] rsp_payload;

   assign zero_payload = (rsp_face == FACE_POS_X) && (rsp_texel_x == '0) &&
                         (rsp_texel_y == '0);
   assign rsp_payload  = {rsp_face, rsp_texel_x, rsp_texel_y, rsp_valid_res};

   // zero vector gives an all-zero response
   `CMFS_ASSERT_NOW(a_zero_vec, rsp_valid && !rsp_valid_res, zero_payload)

   `CMFS_ASSERT_NOW(a_face_range, rsp_valid && rsp_valid_res, rsp_face <= FACE_NEG_Z)

   // pipeline comes out of reset empty
   `CMFS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // held response keeps its payload
   `CMFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind cube_map_face_select_unit cmfs_checker u_cmfs_checker (.*);

// File: tb/cube_map_face_select_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cube map face select unit testbench
// Drives direction vectors with random gaps and response stalls, predicts the
// face and clamped texel coordinates of each request and checks every response
// in order, over a range of face sizes written between traffic phases.
// ----------------------------------------------------------------------------

module cube_map_face_select_unit_tb;
   import cmfs_pkg::*;

   localparam int MAX_SIZE    = 4096;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic signed [DIR_W-1:0] x;
      logic signed [DIR_W-1:0] y;
      logic signed [DIR_W-1:0] z;
   } dir_type;

   typedef struct packed {
      dir_type             dir;
      cmfs_face_type       face;
      logic [TEXEL_W-1:0]  tx;
      logic [TEXEL_W-1:0]  ty;
      logic                hit;
   } lookup_type;

   typedef enum int {
      MIX_UNIFORM,
      MIX_SMALL,
      MIX_TIE,
      MIX_FULL_SCALE,
      MIX_ZERO
   } dir_mix_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_W-1:0]          csr_face_size = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [DIR_W-1:0]   req_dir_x = '0;
   logic signed [DIR_W-1:0]   req_dir_y = '0;
   logic signed [DIR_W-1:0]   req_dir_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_face;
   logic [TEXEL_W-1:0]        rsp_texel_x;
   logic [TEXEL_W-1:0]        rsp_texel_y;
   logic                      rsp_valid_res;

   dir_type          pending_dirs[$];
   lookup_type       expected_lookups[$];
   logic [CSR_W-1:0] face_size_cfg = CSR_W'(FACE_SIZE_RESET);
   int               requests_queued = 0;
   int               lookups_checked = 0;
   int               zero_vectors = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               req_gap = 0;
   int               rsp_wait = 0;
   bit               req_calm = 1'b0;
   bit               rsp_calm = 1'b0;

   cube_map_face_select_unit #(
      .MAX_FACE_SIZE(MAX_SIZE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_face_size(csr_face_size),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_face(rsp_face),
      .rsp_texel_x(rsp_texel_x),
      .rsp_texel_y(rsp_texel_y),
      .rsp_valid_res(rsp_valid_res)
   );

   always #2 clock = ~clock;

   // floor((c + ma) * size / (2 * ma)), clamped to the last texel
   function automatic logic [TEXEL_W-1:0] texel_coord(input int c, input int ma,
                                                      input int size);
      longint q;
      q = (longint'(c + ma) * size) / (2 * longint'(ma));
      if (q > size - 1) q = size - 1;
      return q[TEXEL_W-1:0];
   endfunction

   function automatic lookup_type predict_lookup(input logic signed [DIR_W-1:0] dx,
                                                 input logic signed [DIR_W-1:0] dy,
                                                 input logic signed [DIR_W-1:0] dz,
                                                 input logic [CSR_W-1:0] size_reg);
      int x, y, z, ax, ay, az, ma, sc, tc, size;
      lookup_type r;
      x = dx;
      y = dy;
      z = dz;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      size = size_reg;
      if (size == 0) size = 1;
      if (size > MAX_SIZE) size = MAX_SIZE;
      r.dir = {dx, dy, dz};
      r.tx = '0;
      r.ty = '0;
      r.hit = 1'b0;
      // equal magnitudes: X beats Y, Y beats Z
      if (ax >= ay && ax >= az) begin
         ma = ax;
         tc = -y;
         if (x > 0) begin
            r.face = FACE_POS_X;
            sc = -z;
         end else begin
            r.face = FACE_NEG_X;
            sc = z;
         end
      end else if (ay >= az) begin
         ma = ay;
         sc = x;
         if (y > 0) begin
            r.face = FACE_POS_Y;
            tc = z;
         end else begin
            r.face = FACE_NEG_Y;
            tc = -z;
         end
      end else begin
         ma = az;
         tc = -y;
         if (z > 0) begin
            r.face = FACE_POS_Z;
            sc = x;
         end else begin
            r.face = FACE_NEG_Z;
            sc = -x;
         end
      end
      if (ma == 0) begin
         r.face = FACE_POS_X;
      end else begin
         r.tx = texel_coord(sc, ma, size);
         r.ty = texel_coord(tc, ma, size);
         r.hit = 1'b1;
      end
      return r;
   endfunction

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(1, 11);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic push_dir(input logic signed [DIR_W-1:0] x,
                           input logic signed [DIR_W-1:0] y,
                           input logic signed [DIR_W-1:0] z);
      pending_dirs.push_back({x, y, z});
      requests_queued++;
   endtask

   task automatic queue_random(input int count);
      logic signed [DIR_W-1:0] sx, sy, sz, m;
      dir_mix_type kind;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) kind = MIX_ZERO;
         else if (pick < 18) kind = MIX_SMALL;
         else if (pick < 40) kind = MIX_TIE;
         else if (pick < 55) kind = MIX_FULL_SCALE;
         else kind = MIX_UNIFORM;
         sx = DIR_W'($urandom);
         sy = DIR_W'($urandom);
         sz = DIR_W'($urandom);
         m  = DIR_W'($urandom);
         case (kind)
            MIX_ZERO: begin
               sx = '0;
               sy = '0;
               sz = '0;
            end
            MIX_SMALL: begin
               sx = DIR_W'(int'($urandom_range(0, 6)) - 3);
               sy = DIR_W'(int'($urandom_range(0, 6)) - 3);
               sz = DIR_W'(int'($urandom_range(0, 6)) - 3);
            end
            MIX_TIE: begin
               // two or three components share a magnitude, signs random
               pick = $urandom_range(0, 3);
               sx = sx >>> 2;
               sy = sy >>> 2;
               sz = sz >>> 2;
               if (pick != 2) sx = $urandom_range(0, 1) ? m : -m;
               if (pick != 1) sy = $urandom_range(0, 1) ? m : -m;
               if (pick != 0) sz = $urandom_range(0, 1) ? m : -m;
            end
            MIX_FULL_SCALE: begin
               m = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               case ($urandom_range(0, 2))
                  0: sx = m;
                  1: sy = m;
                  default: sz = m;
               endcase
            end
            default: ;
         endcase
         push_dir(sx, sy, sz);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (lookups_checked != requests_queued);
   endtask

   task automatic write_face_size(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_face_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      face_size_cfg = value;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d of %0d lookups checked",
                  cycle_count, lookups_checked, requests_queued);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : request_driver
      dir_type next_dir;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_lookups.push_back(predict_lookup(req_dir_x, req_dir_y, req_dir_z,
                                                      face_size_cfg));
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (pending_dirs.size() != 0) begin
               next_dir = pending_dirs.pop_front();
               req_valid <= 1'b1;
               req_dir_x <= next_dir.x;
               req_dir_y <= next_dir.y;
               req_dir_z <= next_dir.z;
               req_gap <= draw_wait(req_calm);
               if ($urandom_range(0, 49) == 0) req_calm <= !req_calm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_checker
      lookup_type want;
      int wait_n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         wait_n = (rsp_wait != 0) ? rsp_wait - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_lookups.pop_front();
               lookups_checked++;
               if (!want.hit) zero_vectors++;
               if (rsp_face !== want.face)
                  report_mismatch($sformatf("dir (%0d,%0d,%0d) face %0d, expected %0d",
                     $signed(want.dir.x), $signed(want.dir.y), $signed(want.dir.z),
                     rsp_face, want.face));
               if (rsp_texel_x !== want.tx)
                  report_mismatch($sformatf("dir (%0d,%0d,%0d) texel_x %0d, expected %0d",
                     $signed(want.dir.x), $signed(want.dir.y), $signed(want.dir.z),
                     rsp_texel_x, want.tx));
               if (rsp_texel_y !== want.ty)
                  report_mismatch($sformatf("dir (%0d,%0d,%0d) texel_y %0d, expected %0d",
                     $signed(want.dir.x), $signed(want.dir.y), $signed(want.dir.z),
                     rsp_texel_y, want.ty));
               if (rsp_valid_res !== want.hit)
                  report_mismatch($sformatf("dir (%0d,%0d,%0d) valid_res %0b, expected %0b",
                     $signed(want.dir.x), $signed(want.dir.y), $signed(want.dir.z),
                     rsp_valid_res, want.hit));
            end
            wait_n = draw_wait(rsp_calm);
            if ($urandom_range(0, 49) == 0) rsp_calm <= !rsp_calm;
         end
         rsp_wait <= wait_n;
         rsp_ready <= (wait_n == 0);
      end
   end

   initial begin : stimulus
      int sizes[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests at the reset face size
      push_dir(0, 0, 0);
      push_dir(32767, 0, 0);
      push_dir(-32768, 0, 0);
      push_dir(0, 32767, 0);
      push_dir(0, -32768, 0);
      push_dir(0, 0, 32767);
      push_dir(0, 0, -32768);
      push_dir(100, 100, 100);
      push_dir(100, -100, 50);
      push_dir(-200, 200, 0);
      push_dir(0, 300, -300);
      push_dir(0, -300, 300);
      push_dir(5, -32768, -32768);
      push_dir(-32768, -32768, -32768);
      push_dir(32767, 0, 32767);
      push_dir(-32768, -32768, 0);
      push_dir(-32768, 0, -32768);
      push_dir(32767, -32768, 32767);
      push_dir(-1, 0, 0);
      push_dir(1, 1, -1);
      push_dir(0, 0, -1);
      push_dir(-32768, 32767, 32767);
      push_dir(16'sh5555, -16'sh2AAA, 16'sh1234);
      queue_random(60);

      sizes = '{1, 4096, 0, 8191, 2, 3, 4095, 4097, 255, 1000, 256};
      sizes.push_back($urandom_range(5, 4094));
      foreach (sizes[i]) begin
         wait_drained();
         write_face_size(CSR_W'(sizes[i]));
         queue_random(106);
      end
      wait_drained();
      repeat (40) @(posedge clock);

      $display("checked %0d lookups (%0d zero vectors) over %0d face size settings",
               lookups_checked, zero_vectors, sizes.size() + 1);
      $display("sizes ran from 0 and 1 up to 4096 and the saturating 8191, all faces and ties");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: cube_map_face_select_unit.f
+incdir+hw/rtl
hw/rtl/cmfs_pkg.sv
hw/rtl/cmfs_div_pipe.sv
hw/rtl/cube_map_face_select_unit.sv
hw/rtl/cmfs_checker.sv
tb/cube_map_face_select_unit_tb.sv
